// ----- rtl/core/inverse_cdf_table_sampler_core_macros.svh -----
// Assertion macros for the inverse-CDF table sampler core.
// Used by inverse_cdf_table_sampler_core.sv; expects clk and rst_n in scope.
`ifndef INVERSE_CDF_TABLE_SAMPLER_CORE_MACROS_SVH
`define INVERSE_CDF_TABLE_SAMPLER_CORE_MACROS_SVH

// same-cycle implication
`define ICDF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icdf assertion failed");

// next-cycle implication
`define ICDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icdf assertion failed");

`endif

// ----- rtl/core/icdf_pkg.sv -----
// Package for the inverse-CDF table sampler: widths, codes, state types and
// angle helper functions. No dependencies.
package icdf_pkg;

  localparam int SLOT_W = 20;
  localparam int ENT_W  = 13;
  localparam int CNT_W  = 14;
  localparam int SUM_W  = 45;
  localparam int ANG_W  = 11;
  localparam int GRD_W  = 9;

  localparam logic [SLOT_W:0] SLOTS_C       = 21'd1048576;
  localparam logic [CNT_W-1:0] MAX_ENTRIES_C = 14'd8192;
  localparam logic [13:0]      RECIP5_C      = 14'd13108;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_BUILD = 2'd1;
  localparam logic [1:0] KIND_DRAW  = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [1:0] MODE_ALL   = 2'd0;
  localparam logic [1:0] MODE_ALPHA = 2'd1;

  localparam logic signed [GRD_W-1:0] ALPHA_PHI_LO = -9'sd67;
  localparam logic signed [GRD_W-1:0] ALPHA_PHI_HI = -9'sd47;
  localparam logic signed [GRD_W-1:0] ALPHA_PSI_LO = -9'sd57;
  localparam logic signed [GRD_W-1:0] ALPHA_PSI_HI = -9'sd37;
  localparam logic signed [GRD_W-1:0] BETA_PHI_LO  = -9'sd149;
  localparam logic signed [GRD_W-1:0] BETA_PHI_HI  = -9'sd109;
  localparam logic signed [GRD_W-1:0] BETA_PSI_LO  = 9'sd103;
  localparam logic signed [GRD_W-1:0] BETA_PSI_HI  = 9'sd145;

  typedef enum logic [3:0] {
    S_IDLE, S_DOWN, S_DIDX, S_DCHK, S_QW1, S_QW2, S_QRD, S_QCMP,
    S_BRD, S_BLAT, S_BDIV, S_BRND, S_BEND, S_FILL
  } state_t;

  typedef enum logic [1:0] {PH_BUILD, PH_QHI, PH_QLO} phase_t;

  // angle is a multiple of 5 in -180..175
  function automatic logic on_grid(input logic signed [ANG_W-1:0] a);
    logic [ANG_W-1:0] v;
    logic [4:0] s;
    logic [4:0] t;
    v = ANG_W'(a + 11'sd180);
    s = 5'(v[3:0]) + 5'(v[7:4]) + 5'(v[8]);
    t = 5'(s[3:0]) + 5'(s[4]);
    return (a >= -11'sd180) && (a <= 11'sd175) &&
           (t == 5'd0 || t == 5'd5 || t == 5'd10 || t == 5'd15);
  endfunction

  // grid step count (|a|+2)/5 via reciprocal multiply
  function automatic logic [7:0] grid_mag(input logic signed [ANG_W-1:0] a);
    logic [ANG_W-1:0] mag;
    logic [ANG_W-1:0] x;
    logic [24:0] prod;
    mag  = a[ANG_W-1] ? ANG_W'(-a) : ANG_W'(a);
    x    = mag + 11'd2;
    prod = 25'(x) * 25'(RECIP5_C);
    return prod[23:16];
  endfunction

  // q*5 with sign, wrapped into -180..175
  function automatic logic signed [GRD_W-1:0] grid_wrap(input logic [7:0] q,
                                                          input logic neg);
    logic signed [12:0] g;
    g = $signed({3'b0, q, 2'b0}) + $signed({5'b0, q});
    if (neg) g = -g;
    for (int j = 0; j < 3; j++) begin
      if (g >= 13'sd180) g = g - 13'sd360;
    end
    for (int j = 0; j < 3; j++) begin
      if (g < -13'sd180) g = g + 13'sd360;
    end
    return g[GRD_W-1:0];
  endfunction

  function automatic logic in_window(input logic [1:0] mode,
                                     input logic signed [GRD_W-1:0] p,
                                     input logic signed [GRD_W-1:0] s);
    logic ok;
    case (mode)
      MODE_ALL:   ok = 1'b1;
      MODE_ALPHA: ok = p >= ALPHA_PHI_LO && p <= ALPHA_PHI_HI &&
                       s >= ALPHA_PSI_LO && s <= ALPHA_PSI_HI;
      default:    ok = p >= BETA_PHI_LO && p <= BETA_PHI_HI &&
                       s >= BETA_PSI_LO && s <= BETA_PSI_HI;
    endcase
    return ok;
  endfunction

endpackage

// ----- rtl/core/inverse_cdf_table_sampler_core.sv -----
// Inverse-CDF table sampler. Load: no result, next beat on the next edge.
// Draw: slot and entry reads, window check; busy until done, result only in window.
// Build: per entry, a boundary from the shared 20-step divider, then one slot per
// cycle (1048576 slot-table writes in all). Query: grid rounding, a scan of entries,
// plus up to two boundary divides. Results cannot be stalled. Synchronous active-low
// reset clears control state only; stores have no clearing pass.
`include "inverse_cdf_table_sampler_core_macros.svh"

module inverse_cdf_table_sampler_core
  import icdf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_kind,
  input  logic signed [ANG_W-1:0] in_angle_phi,
  input  logic signed [ANG_W-1:0] in_angle_psi,
  input  logic [31:0]             in_entry_weight,
  input  logic [SLOT_W-1:0]       in_uniform_slot,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_wdata,
  output logic                    out_valid,
  output logic [1:0]              out_result_status,
  output logic [ENT_W-1:0]        out_entry_index,
  output logic signed [GRD_W-1:0] out_phi,
  output logic signed [GRD_W-1:0] out_psi,
  output logic [SLOT_W:0]         out_slot_count
);

  // ---------------------------------------------------------------------
  // Stores. Entry stores are written by loads at entry_total; the slot
  // table is written one slot per cycle by the build sweep, pausing for each divide.
  // ---------------------------------------------------------------------
  logic signed [GRD_W-1:0] phi_mem [2**ENT_W];
  logic signed [GRD_W-1:0] psi_mem [2**ENT_W];
  logic [SUM_W-1:0]        rw_mem  [2**ENT_W];
  logic [ENT_W-1:0]        slot_mem [2**SLOT_W];

  logic signed [GRD_W-1:0] phi_q, psi_q;
  logic [SUM_W-1:0]        rw_q;
  logic [ENT_W-1:0]        own_q;
  logic [ENT_W-1:0]        ent_raddr;

  // control and working registers
  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [1:0]        mode_r;
  logic [CNT_W-1:0]  entry_total_r, entry_total_nxt;
  logic              built_r, built_nxt;
  logic [SUM_W-1:0]  last_sum_r, last_sum_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic signed [ANG_W-1:0] aphi_r, aphi_nxt, apsi_r, apsi_nxt;
  logic [7:0]        qphi_r, qphi_nxt, qpsi_r, qpsi_nxt;
  logic              nphi_r, nphi_nxt, npsi_r, npsi_nxt;
  logic signed [GRD_W-1:0] gp_r, gp_nxt, gs_r, gs_nxt;
  logic [ENT_W-1:0]  i_r, i_nxt, bidx_r, bidx_nxt, idx_r, idx_nxt;
  logic [SLOT_W:0]   k_r, k_nxt, bnd_r, bnd_nxt, hi_r, hi_nxt;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [SLOT_W-1:0] quo_r, quo_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic signed [GRD_W-1:0] op_r, op_nxt, os_r, os_nxt;

  // result beat register
  logic                    ov_r, ov_nxt;
  logic [1:0]              ost_r, ost_nxt;
  logic [ENT_W-1:0]        oidx_r, oidx_nxt;
  logic signed [GRD_W-1:0] ophi_r, ophi_nxt, opsi_r, opsi_nxt;
  logic [SLOT_W:0]         ocnt_r, ocnt_nxt;

  logic              accept;
  logic              ent_we;
  logic              slot_we;
  logic [SUM_W-1:0]  total;
  logic [SUM_W:0]    rem2;
  logic [ENT_W-1:0]  draw_idx;
  logic              last_entry;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign total    = last_sum_r;
  assign rem2     = {rem_r, 1'b0};
  assign draw_idx = ({1'b0, own_q} >= entry_total_r) ? '0 : own_q;
  assign last_entry = (CNT_W'(i_r) + 14'd1) == entry_total_r;

  // a load is kept only with nonzero weight, both angles on grid, room left
  assign ent_we = accept && (in_kind == KIND_LOAD) && (in_entry_weight != '0) &&
                  on_grid(in_angle_phi) && on_grid(in_angle_psi) &&
                  !entry_total_r[CNT_W-1];
  assign slot_we = (state_r == S_FILL) && (k_r < bnd_r);

  always_comb begin
    case (state_r)
      S_DIDX:  ent_raddr = draw_idx;
      S_BRD:   ent_raddr = bidx_r;
      default: ent_raddr = i_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      phi_mem[entry_total_r[ENT_W-1:0]] <= in_angle_phi[GRD_W-1:0];
      psi_mem[entry_total_r[ENT_W-1:0]] <= in_angle_psi[GRD_W-1:0];
      rw_mem[entry_total_r[ENT_W-1:0]]  <= last_sum_nxt;
    end
    phi_q <= phi_mem[ent_raddr];
    psi_q <= psi_mem[ent_raddr];
    rw_q  <= rw_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[k_r[SLOT_W-1:0]] <= i_r;
    end
    own_q <= slot_mem[slot_r];
  end

  // ---------------------------------------------------------------------
  // Sequencer. The divider (S_BLAT..S_BRND) computes one slot boundary
  // round(cum * 2^20 / total) a bit per cycle and is shared by build and
  // query; phase_r says where S_BEND hands the boundary back.
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;       phase_nxt = phase_r;
    entry_total_nxt = entry_total_r;
    built_nxt = built_r;       last_sum_nxt = last_sum_r;
    slot_nxt = slot_r;         aphi_nxt = aphi_r;   apsi_nxt = apsi_r;
    qphi_nxt = qphi_r;         qpsi_nxt = qpsi_r;
    nphi_nxt = nphi_r;         npsi_nxt = npsi_r;
    gp_nxt = gp_r;             gs_nxt = gs_r;
    i_nxt = i_r;               bidx_nxt = bidx_r;   idx_nxt = idx_r;
    k_nxt = k_r;               bnd_nxt = bnd_r;     hi_nxt = hi_r;
    rem_nxt = rem_r;           quo_nxt = quo_r;     cnt_nxt = cnt_r;
    op_nxt = op_r;             os_nxt = os_r;
    ov_nxt = 1'b0;             ost_nxt = ST_OK;     oidx_nxt = '0;
    ophi_nxt = '0;             opsi_nxt = '0;       ocnt_nxt = '0;

    if (ent_we) begin
      last_sum_nxt    = (entry_total_r == '0 ? '0 : last_sum_r) +
                        SUM_W'(in_entry_weight);
      entry_total_nxt = entry_total_r + 14'd1;
      built_nxt       = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          slot_nxt = in_uniform_slot;
          aphi_nxt = in_angle_phi;
          apsi_nxt = in_angle_psi;
          case (in_kind)
            KIND_BUILD: begin
              if (entry_total_r == '0) begin
                built_nxt = 1'b0;
                ov_nxt    = 1'b1;
                ost_nxt   = ST_EMPTY;
              end else begin
                i_nxt     = '0;
                bidx_nxt  = '0;
                k_nxt     = '0;
                phase_nxt = PH_BUILD;
                state_nxt = S_BRD;
              end
            end
            KIND_DRAW, KIND_QUERY: begin
              if (!built_r) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_EMPTY;
              end else begin
                state_nxt = (in_kind == KIND_DRAW) ? S_DOWN : S_QW1;
              end
            end
            default: ;
          endcase
        end
      end
      // draw: slot table read, entry read, window check
      S_DOWN: state_nxt = S_DIDX;
      S_DIDX: begin
        idx_nxt   = draw_idx;
        state_nxt = S_DCHK;
      end
      S_DCHK: begin
        if (in_window(mode_r, phi_q, psi_q)) begin
          ov_nxt   = 1'b1;
          oidx_nxt = idx_r;
          ophi_nxt = phi_q;
          opsi_nxt = psi_q;
        end
        state_nxt = S_IDLE;
      end
      // query: round to grid, then linear scan of stored entries
      S_QW1: begin
        qphi_nxt  = grid_mag(aphi_r);
        qpsi_nxt  = grid_mag(apsi_r);
        nphi_nxt  = aphi_r[ANG_W-1];
        npsi_nxt  = apsi_r[ANG_W-1];
        state_nxt = S_QW2;
      end
      S_QW2: begin
        gp_nxt    = grid_wrap(qphi_r, nphi_r);
        gs_nxt    = grid_wrap(qpsi_r, npsi_r);
        i_nxt     = '0;
        state_nxt = S_QRD;
      end
      S_QRD: state_nxt = S_QCMP;
      S_QCMP: begin
        if (phi_q == gp_r && psi_q == gs_r) begin
          idx_nxt   = i_r;
          op_nxt    = phi_q;
          os_nxt    = psi_q;
          bidx_nxt  = i_r;
          phase_nxt = PH_QHI;
          state_nxt = S_BRD;
        end else if (last_entry) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_NOT_FOUND;
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r + 13'd1;
          state_nxt = S_QRD;
        end
      end
      // shared boundary divider
      S_BRD: state_nxt = S_BLAT;
      S_BLAT: begin
        if (rw_q >= total) begin
          bnd_nxt   = SLOTS_C;
          state_nxt = S_BEND;
        end else begin
          rem_nxt   = rw_q;
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_BDIV;
        end
      end
      S_BDIV: begin
        if (rem2 >= {1'b0, total}) begin
          rem_nxt = SUM_W'(rem2 - {1'b0, total});
          quo_nxt = {quo_r[SLOT_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem2[SUM_W-1:0];
          quo_nxt = {quo_r[SLOT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(SLOT_W - 1)) state_nxt = S_BRND;
      end
      S_BRND: begin
        // round half up
        bnd_nxt   = {1'b0, quo_r} + ((rem2 >= {1'b0, total}) ? 21'd1 : 21'd0);
        state_nxt = S_BEND;
      end
      S_BEND: begin
        case (phase_r)
          PH_BUILD: state_nxt = S_FILL;
          PH_QHI: begin
            hi_nxt = bnd_r;
            if (i_r == '0) begin
              ov_nxt    = 1'b1;
              oidx_nxt  = idx_r;
              ophi_nxt  = op_r;
              opsi_nxt  = os_r;
              ocnt_nxt  = bnd_r;
              state_nxt = S_IDLE;
            end else begin
              bidx_nxt  = i_r - 13'd1;
              phase_nxt = PH_QLO;
              state_nxt = S_BRD;
            end
          end
          default: begin
            ov_nxt    = 1'b1;
            oidx_nxt  = idx_r;
            ophi_nxt  = op_r;
            opsi_nxt  = os_r;
            ocnt_nxt  = (hi_r > bnd_r) ? hi_r - bnd_r : '0;
            state_nxt = S_IDLE;
          end
        endcase
      end
      // build: write owner into every slot up to this entry's boundary
      S_FILL: begin
        if (k_r < bnd_r) begin
          k_nxt = k_r + 21'd1;
        end else if (last_entry) begin
          built_nxt = 1'b1;
          ov_nxt    = 1'b1;
          ocnt_nxt  = (SLOT_W + 1)'(entry_total_r);
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r + 13'd1;
          bidx_nxt  = i_r + 13'd1;
          state_nxt = S_BRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      phase_r       <= PH_BUILD;
      mode_r        <= MODE_ALL;
      entry_total_r <= '0;
      built_r       <= 1'b0;
      ov_r          <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      if (cfg_we) mode_r <= cfg_wdata;
      entry_total_r <= entry_total_nxt;
      built_r       <= built_nxt;
      ov_r          <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_sum_r <= last_sum_nxt;
    slot_r <= slot_nxt;   aphi_r <= aphi_nxt;  apsi_r <= apsi_nxt;
    qphi_r <= qphi_nxt;   qpsi_r <= qpsi_nxt;
    nphi_r <= nphi_nxt;   npsi_r <= npsi_nxt;
    gp_r   <= gp_nxt;     gs_r   <= gs_nxt;
    i_r    <= i_nxt;      bidx_r <= bidx_nxt;  idx_r <= idx_nxt;
    k_r    <= k_nxt;      bnd_r  <= bnd_nxt;   hi_r  <= hi_nxt;
    rem_r  <= rem_nxt;    quo_r  <= quo_nxt;   cnt_r <= cnt_nxt;
    op_r   <= op_nxt;     os_r   <= os_nxt;
    ost_r  <= ost_nxt;    oidx_r <= oidx_nxt;
    ophi_r <= ophi_nxt;   opsi_r <= opsi_nxt;  ocnt_r <= ocnt_nxt;
  end

  assign out_valid         = ov_r;
  assign out_result_status = ost_r;
  assign out_entry_index   = oidx_r;
  assign out_phi           = ophi_r;
  assign out_psi           = opsi_r;
  assign out_slot_count    = ocnt_r;

  // a load beat never produces a result
  `ICDF_ASSERT_NEXT(a_load_silent, accept && in_kind == KIND_LOAD, !out_valid)
  // entry count stays within the store
  `ICDF_ASSERT_NOW(a_total_cap, 1'b1, entry_total_r <= MAX_ENTRIES_C)
  // a built table always has entries
  `ICDF_ASSERT_NOW(a_built_nonempty, built_r, entry_total_r != '0)
  // fill sweep never runs past the slot table
  `ICDF_ASSERT_NOW(a_fill_range, state_r == S_FILL, k_r <= SLOTS_C && bnd_r <= SLOTS_C)

endmodule
